// ===== hdl/obms_pkg.sv =====
package obms_pkg;

    localparam int MEMORY_WORDS  = 4096;
    localparam int MAX_RUN_WORDS = 126;

    localparam int ADDR_W    = $clog2(MEMORY_WORDS);
    localparam int ROW_OFF_W = 4;
    localparam int ROW_BITS  = 2 ** ROW_OFF_W;
    localparam int ROW_IDX_W = (ADDR_W > ROW_OFF_W) ? (ADDR_W - ROW_OFF_W) : 1;
    localparam int MARK_ROWS = 2 ** ROW_IDX_W;

    localparam int CURSOR_W = 13;
    localparam int LEFT_W   = 7;
    localparam int WORD_W   = 12;
    localparam int ERR_W    = 16;

    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_DEFINE = 3'd1;
    localparam logic [2:0] KIND_FETCH  = 3'd2;
    localparam logic [2:0] KIND_START  = 3'd3;
    localparam logic [2:0] KIND_STEP   = 3'd4;

    localparam logic [7:0] HDR_O = 8'h4F;
    localparam logic [7:0] HDR_B = 8'h42;
    localparam logic [7:0] HDR_J = 8'h4A;
    localparam logic [7:0] HDR_8 = 8'h38;

    localparam logic [5:0] SIX_BITS = 6'h3F;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] address;
        logic [11:0] word;
        logic        allow_redefine;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [11:0] read_word;
        logic        redefined_flag;
        logic [15:0] errors_so_far;
        logic        dump_done;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } word_req_t;

    typedef struct packed {
        logic                 clr;
        logic                 we;
        logic [ROW_IDX_W-1:0] wrow;
        logic [ROW_BITS-1:0]  wbits;
        logic [ROW_IDX_W-1:0] rrow;
    } mark_req_t;

    function automatic logic [ROW_IDX_W-1:0] row_of(input logic [ADDR_W-1:0] a);
        row_of = ROW_IDX_W'(a >> ROW_OFF_W);
    endfunction

endpackage

// ===== hdl/obms_word_store.sv =====
module obms_word_store (
    input  logic                        clk,
    input  obms_pkg::word_req_t         req,
    output logic [obms_pkg::WORD_W-1:0] rdata
);

    logic [obms_pkg::WORD_W-1:0] mem [obms_pkg::MEMORY_WORDS];
    logic [obms_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/obms_mark_store.sv =====
module obms_mark_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  obms_pkg::mark_req_t           req,
    output logic [obms_pkg::ROW_BITS-1:0] rbits
);

    logic [obms_pkg::ROW_BITS-1:0]  mem [obms_pkg::MARK_ROWS];
    logic [obms_pkg::MARK_ROWS-1:0] row_valid_reg;
    logic [obms_pkg::ROW_BITS-1:0]  rdata_reg;
    logic                           rvalid_reg;

    // row valid bits, dropped all at once on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                row_valid_reg <= '0;
            end
            else if (req.we)
            begin
                row_valid_reg[req.wrow] <= 1'b1;
            end
            rvalid_reg <= row_valid_reg[req.rrow];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.wrow] <= req.wbits;
        end
        rdata_reg <= mem[req.rrow];
    end

    assign rbits = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== hdl/obms_seq.sv =====
module obms_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  obms_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output obms_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [11:0]                   cfg_data,
    output obms_pkg::word_req_t           word_req,
    input  logic [obms_pkg::WORD_W-1:0]   word_rdata,
    output obms_pkg::mark_req_t           mark_req,
    input  logic [obms_pkg::ROW_BITS-1:0] mark_rbits
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_LOOK     = 5'b00010,
        ST_SCAN_REQ = 5'b00100,
        ST_SCAN     = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    localparam int NBYTES = 6;

    state_t                           state_reg, state_next;
    obms_pkg::in_item_t               item_reg, item_next;
    logic [11:0]                      entry_reg, entry_next;
    logic [obms_pkg::ERR_W-1:0]       err_reg, err_next;
    logic [obms_pkg::CURSOR_W-1:0]    cursor_reg, cursor_next;
    logic [obms_pkg::LEFT_W-1:0]      left_reg, left_next;
    logic [obms_pkg::CURSOR_W-1:0]    scan_pos_reg, scan_pos_next;
    logic [obms_pkg::LEFT_W-1:0]      len_reg, len_next;
    logic [obms_pkg::WORD_W-1:0]      hold_reg, hold_next;
    logic [7:0]                       bytes_reg [NBYTES];
    logic [7:0]                       bytes_next [NBYTES];
    logic [2:0]                       cnt_reg, cnt_next;
    logic                             bmode_reg, bmode_next;
    logic [obms_pkg::WORD_W-1:0]      rd_reg, rd_next;
    logic                             flag_reg, flag_next;

    logic                             in_fire;
    logic                             out_fire;
    logic                             cursor_done;
    logic                             in_range;
    logic [obms_pkg::ADDR_W-1:0]      look_addr;
    logic [obms_pkg::ADDR_W-1:0]      req_addr;
    logic [obms_pkg::ROW_OFF_W-1:0]   look_off;
    logic                             mark_bit;
    logic                             def_flag;
    logic [obms_pkg::ROW_OFF_W-1:0]   scan_off;
    logic [obms_pkg::ROW_BITS-1:0]    scan_shifted;
    logic [obms_pkg::ROW_OFF_W:0]     scan_ones;
    logic [obms_pkg::ROW_OFF_W:0]     scan_span;
    logic [7:0]                       scan_sum;
    logic [obms_pkg::CURSOR_W-1:0]    scan_next_pos;
    logic                             scan_more;
    logic [obms_pkg::LEFT_W-1:0]      run_len;

    function automatic logic [obms_pkg::ROW_OFF_W:0] lead_ones(
        input logic [obms_pkg::ROW_BITS-1:0] v
    );
        logic [obms_pkg::ROW_OFF_W:0] n;
        logic                         stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 0; i < obms_pkg::ROW_BITS; i++)
        begin
            if (!stop && v[i])
            begin
                n = n + 1'b1;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        lead_ones = n;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_fire  = out_valid && out_ready;
    assign cfg_ready = 1'b1;

    assign cursor_done = (cursor_reg >= obms_pkg::CURSOR_W'(obms_pkg::MEMORY_WORDS));
    assign in_range    = ({1'b0, item_reg.address} < 13'(obms_pkg::MEMORY_WORDS));

    assign look_addr = (item_reg.kind == obms_pkg::KIND_STEP)
                     ? cursor_reg[obms_pkg::ADDR_W-1:0]
                     : item_reg.address[obms_pkg::ADDR_W-1:0];
    assign look_off  = look_addr[obms_pkg::ROW_OFF_W-1:0];
    assign mark_bit  = mark_rbits[look_off];
    assign def_flag  = in_range && mark_bit && !item_reg.allow_redefine;

    // read address comes straight from the request so data is ready in look
    assign req_addr = (in_data.kind == obms_pkg::KIND_STEP)
                    ? cursor_reg[obms_pkg::ADDR_W-1:0]
                    : in_data.address[obms_pkg::ADDR_W-1:0];

    // run scan, one mark row per pass
    assign scan_off      = scan_pos_reg[obms_pkg::ROW_OFF_W-1:0];
    assign scan_shifted  = mark_rbits >> scan_off;
    assign scan_ones     = lead_ones(scan_shifted);
    assign scan_span     = (obms_pkg::ROW_OFF_W+1)'(obms_pkg::ROW_BITS) - {1'b0, scan_off};
    assign scan_sum      = {1'b0, len_reg} + 8'(scan_ones);
    assign scan_next_pos = scan_pos_reg + obms_pkg::CURSOR_W'(scan_ones);
    assign scan_more     = (scan_ones == scan_span)
                        && (scan_sum < 8'(obms_pkg::MAX_RUN_WORDS))
                        && (scan_next_pos < obms_pkg::CURSOR_W'(obms_pkg::MEMORY_WORDS));
    assign run_len       = (scan_sum > 8'(obms_pkg::MAX_RUN_WORDS))
                         ? obms_pkg::LEFT_W'(obms_pkg::MAX_RUN_WORDS)
                         : scan_sum[obms_pkg::LEFT_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        entry_next    = entry_reg;
        err_next      = err_reg;
        cursor_next   = cursor_reg;
        left_next     = left_reg;
        scan_pos_next = scan_pos_reg;
        len_next      = len_reg;
        hold_next     = hold_reg;
        bytes_next    = bytes_reg;
        cnt_next      = cnt_reg;
        bmode_next    = bmode_reg;
        rd_next       = rd_reg;
        flag_next     = flag_reg;

        word_req.we    = 1'b0;
        word_req.waddr = item_reg.address[obms_pkg::ADDR_W-1:0];
        word_req.wdata = item_reg.word;
        word_req.raddr = req_addr;

        mark_req.clr   = 1'b0;
        mark_req.we    = 1'b0;
        mark_req.wrow  = obms_pkg::row_of(item_reg.address[obms_pkg::ADDR_W-1:0]);
        mark_req.wbits = mark_rbits | (obms_pkg::ROW_BITS'(1) << look_off);
        mark_req.rrow  = obms_pkg::row_of(req_addr);

        if (cfg_valid)
        begin
            entry_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_next  = in_data;
                    state_next = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                state_next = ST_EMIT;
                cnt_next   = 3'd1;
                bmode_next = 1'b0;
                rd_next    = '0;
                flag_next  = 1'b0;
                unique case (item_reg.kind)
                    obms_pkg::KIND_CLEAR:
                    begin
                        mark_req.clr = 1'b1;
                    end

                    obms_pkg::KIND_DEFINE:
                    begin
                        if (in_range)
                        begin
                            word_req.we = 1'b1;
                            mark_req.we = 1'b1;
                        end
                        flag_next = def_flag;
                        if (def_flag && (err_reg != '1))
                        begin
                            err_next = err_reg + 1'b1;
                        end
                    end

                    obms_pkg::KIND_FETCH:
                    begin
                        if (in_range && mark_bit)
                        begin
                            rd_next = word_rdata;
                        end
                    end

                    obms_pkg::KIND_START:
                    begin
                        bytes_next[0] = obms_pkg::HDR_O;
                        bytes_next[1] = obms_pkg::HDR_B;
                        bytes_next[2] = obms_pkg::HDR_J;
                        bytes_next[3] = obms_pkg::HDR_8;
                        bytes_next[4] = {2'b00, entry_reg[11:6] & obms_pkg::SIX_BITS};
                        bytes_next[5] = {2'b00, entry_reg[5:0]};
                        cnt_next      = 3'd6;
                        bmode_next    = 1'b1;
                        cursor_next   = '0;
                        left_next     = '0;
                    end

                    obms_pkg::KIND_STEP:
                    begin
                        if (!cursor_done)
                        begin
                            if (left_reg != '0)
                            begin
                                bytes_next[0] = {2'b00, word_rdata[11:6]};
                                bytes_next[1] = {2'b00, word_rdata[5:0]};
                                cnt_next      = 3'd2;
                                bmode_next    = 1'b1;
                                left_next     = left_reg - 1'b1;
                                cursor_next   = cursor_reg + 1'b1;
                            end
                            else if (mark_bit)
                            begin
                                hold_next     = word_rdata;
                                scan_pos_next = cursor_reg;
                                len_next      = '0;
                                state_next    = ST_SCAN_REQ;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            ST_SCAN_REQ:
            begin
                mark_req.rrow = obms_pkg::row_of(scan_pos_reg[obms_pkg::ADDR_W-1:0]);
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (scan_more)
                begin
                    len_next      = scan_sum[obms_pkg::LEFT_W-1:0];
                    scan_pos_next = scan_next_pos;
                    state_next    = ST_SCAN_REQ;
                end
                else
                begin
                    bytes_next[0] = 8'd3 + {run_len, 1'b0};
                    bytes_next[1] = {2'b00, cursor_reg[11:6]};
                    bytes_next[2] = {2'b00, cursor_reg[5:0]};
                    bytes_next[3] = {2'b00, hold_reg[11:6]};
                    bytes_next[4] = {2'b00, hold_reg[5:0]};
                    cnt_next      = 3'd5;
                    bmode_next    = 1'b1;
                    rd_next       = '0;
                    flag_next     = 1'b0;
                    left_next     = run_len - 1'b1;
                    cursor_next   = cursor_reg + 1'b1;
                    state_next    = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_fire)
                begin
                    for (int i = 0; i < NBYTES - 1; i++)
                    begin
                        bytes_next[i] = bytes_reg[i+1];
                    end
                    bytes_next[NBYTES-1] = '0;
                    cnt_next             = cnt_reg - 1'b1;
                    if (cnt_reg == 3'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            entry_reg  <= '0;
            err_reg    <= '0;
            cursor_reg <= '0;
            left_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            entry_reg  <= entry_next;
            err_reg    <= err_next;
            cursor_reg <= cursor_next;
            left_reg   <= left_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_pos_reg <= scan_pos_next;
        len_reg      <= len_next;
        hold_reg     <= hold_next;
        bytes_reg    <= bytes_next;
        bmode_reg    <= bmode_next;
        rd_reg       <= rd_next;
        flag_reg     <= flag_next;
    end

    always_comb
    begin
        out_data.out_byte       = bmode_reg ? bytes_reg[0] : 8'd0;
        out_data.byte_valid     = bmode_reg;
        out_data.read_word      = rd_reg;
        out_data.redefined_flag = flag_reg;
        out_data.errors_so_far  = err_reg;
        out_data.dump_done      = cursor_done;
        out_data.last           = (cnt_reg == 3'd1);
    end

`ifndef SYNTHESIS
    a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (err_reg == $past(err_reg)) || (err_reg == $past(err_reg) + 16'd1))
        else $error("error count moved by more than one");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_data.last) |=> in_ready)
        else $error("block not ready after final result");

    a_clr_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        mark_req.clr |-> !mark_req.we)
        else $error("mark clear and write in one cycle");

    a_block_in_memory: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != '0) |-> !cursor_done)
        else $error("block runs past end of memory");
`endif

endmodule

// ===== hdl/object_memory_block_serializer_top.sv =====
// latency: clear, define, fetch give one result two cycles after the request
// dump start gives six results from the second cycle, one per cycle taken
// dump step at a block start scans mark rows two cycles each, up to nine rows
// throughput: one request at a time, 2 to about 20 cycles plus one per result
// reset: all marks read as undefined at once, word memory is left uninitialized
module object_memory_block_serializer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  obms_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output obms_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [11:0]         cfg_data
);

    obms_pkg::word_req_t           word_req;
    obms_pkg::mark_req_t           mark_req;
    logic [obms_pkg::WORD_W-1:0]   word_rdata;
    logic [obms_pkg::ROW_BITS-1:0] mark_rbits;

    obms_word_store u_word_store (
        .clk   (clk),
        .req   (word_req),
        .rdata (word_rdata)
    );

    obms_mark_store u_mark_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mark_req),
        .rbits (mark_rbits)
    );

    obms_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .word_req   (word_req),
        .word_rdata (word_rdata),
        .mark_req   (mark_req),
        .mark_rbits (mark_rbits)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_REPORTS = 40;

    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    obms_pkg::in_item_t   in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    obms_pkg::out_item_t  out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [11:0]          cfg_data  = '0;

    // model of the block
    logic [obms_pkg::WORD_W-1:0]       word_mem [obms_pkg::MEMORY_WORDS];
    logic [obms_pkg::MEMORY_WORDS-1:0] mark_bits  = '0;
    logic [obms_pkg::ERR_W-1:0]        err_cnt    = '0;
    logic [obms_pkg::CURSOR_W-1:0]     cursor     = '0;
    logic [obms_pkg::LEFT_W-1:0]       words_left = '0;
    logic [11:0]                       entry_reg  = '0;

    obms_pkg::out_item_t item_results [$];
    obms_pkg::out_item_t results_due [$];
    obms_pkg::in_item_t  requests_pending [$];

    int fail_count  = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int take_gap    = 0;
    int take_draw   = 0;
    bit send_calm   = 1'b0;
    bit take_calm   = 1'b0;
    bit steady      = 1'b0;

    always #4 clk = ~clk;

    object_memory_block_serializer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic void add_result(input logic [7:0] b, input logic v,
                                       input logic [11:0] rd, input logic f);
        obms_pkg::out_item_t r;
        r = '0;
        r.out_byte       = b;
        r.byte_valid     = v;
        r.read_word      = rd;
        r.redefined_flag = f;
        item_results.push_back(r);
    endfunction

    function automatic void add_pair(input logic [11:0] v);
        add_result({2'b00, v[11:6]}, 1'b1, 12'd0, 1'b0);
        add_result({2'b00, v[5:0]}, 1'b1, 12'd0, 1'b0);
    endfunction

    function automatic void serialize_item(input obms_pkg::in_item_t it);
        int run;
        int c;
        logic f;
        obms_pkg::out_item_t r;
        item_results.delete();
        case (it.kind)
            obms_pkg::KIND_CLEAR:
            begin
                mark_bits = '0;
                add_result(8'd0, 1'b0, 12'd0, 1'b0);
            end
            obms_pkg::KIND_DEFINE:
            begin
                f = mark_bits[it.address] && !it.allow_redefine;
                if (f && err_cnt != '1)
                    err_cnt = err_cnt + 1'b1;
                mark_bits[it.address] = 1'b1;
                word_mem[it.address]  = it.word;
                add_result(8'd0, 1'b0, 12'd0, f);
            end
            obms_pkg::KIND_FETCH:
            begin
                add_result(8'd0, 1'b0,
                           mark_bits[it.address] ? word_mem[it.address] : 12'd0, 1'b0);
            end
            obms_pkg::KIND_START:
            begin
                add_result(obms_pkg::HDR_O, 1'b1, 12'd0, 1'b0);
                add_result(obms_pkg::HDR_B, 1'b1, 12'd0, 1'b0);
                add_result(obms_pkg::HDR_J, 1'b1, 12'd0, 1'b0);
                add_result(obms_pkg::HDR_8, 1'b1, 12'd0, 1'b0);
                add_pair(entry_reg);
                cursor     = '0;
                words_left = '0;
            end
            obms_pkg::KIND_STEP:
            begin
                if (cursor >= obms_pkg::MEMORY_WORDS)
                begin
                    add_result(8'd0, 1'b0, 12'd0, 1'b0);
                end
                else
                begin
                    c = int'(cursor);
                    if (words_left != 0)
                    begin
                        add_pair(word_mem[c]);
                        words_left = words_left - 1'b1;
                    end
                    else if (mark_bits[c])
                    begin
                        run = 0;
                        while (run < obms_pkg::MAX_RUN_WORDS
                               && c + run < obms_pkg::MEMORY_WORDS
                               && mark_bits[c + run])
                            run++;
                        add_result(8'(3 + 2 * run), 1'b1, 12'd0, 1'b0);
                        add_pair(12'(c));
                        add_pair(word_mem[c]);
                        words_left = obms_pkg::LEFT_W'(run - 1);
                    end
                    else
                    begin
                        add_result(8'd0, 1'b0, 12'd0, 1'b0);
                    end
                    cursor = cursor + 1'b1;
                end
            end
            default:
            begin
                add_result(8'd0, 1'b0, 12'd0, 1'b0);
            end
        endcase
        foreach (item_results[k])
        begin
            r = item_results[k];
            r.errors_so_far = err_cnt;
            r.dump_done     = (cursor >= obms_pkg::MEMORY_WORDS);
            r.last          = (k == item_results.size() - 1);
            results_due.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_result(input obms_pkg::out_item_t got);
        obms_pkg::out_item_t want;
        if (results_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: unexpected result expected none got %h", $time, got);
        end
        else
        begin
            want = results_due.pop_front();
            compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
            compare_field("read_word", 16'(want.read_word), 16'(got.read_word));
            compare_field("redefined_flag", 16'(want.redefined_flag),
                          16'(got.redefined_flag));
            compare_field("errors_so_far", want.errors_so_far, got.errors_so_far);
            compare_field("dump_done", 16'(want.dump_done), 16'(got.dump_done));
            compare_field("last", 16'(want.last), 16'(got.last));
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                serialize_item(in_data);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (requests_pending.size() != 0)
                begin
                    in_data  <= requests_pending.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 11) == 0)
                        send_calm = !send_calm;
                    send_gap <= (steady || send_calm) ? 0 : $urandom_range(0, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b1;
            take_gap  <= 0;
        end
        else if (out_valid && out_ready)
        begin
            check_result(out_data);
            if ($urandom_range(0, 11) == 0)
                take_calm = !take_calm;
            take_draw = (steady || take_calm) ? 0 : $urandom_range(0, 11);
            out_ready <= (take_draw == 0);
            take_gap  <= take_draw;
        end
        else if (!out_ready)
        begin
            if (take_gap <= 1)
                out_ready <= 1'b1;
            take_gap <= take_gap - 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic void queue_request(input logic [2:0] kind, input logic [11:0] addr,
                                          input logic [11:0] word, input logic allow);
        obms_pkg::in_item_t it;
        it.kind           = kind;
        it.address        = addr;
        it.word           = word;
        it.allow_redefine = allow;
        requests_pending.push_back(it);
    endfunction

    function automatic logic [11:0] rand_addr();
        if ($urandom_range(0, 7) == 0)
            return 12'($urandom);
        return 12'($urandom_range(0, 47));
    endfunction

    task automatic drain();
        while (requests_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_entry(input logic [11:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        entry_reg = v;
        @(negedge clk);
    endtask

    task automatic queue_random_mix(input int count);
        int made;
        int pick;
        int steps;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                queue_request(obms_pkg::KIND_DEFINE, rand_addr(), 12'($urandom),
                              1'($urandom));
                made++;
            end
            else if (pick < 60)
            begin
                queue_request(obms_pkg::KIND_FETCH, rand_addr(), 12'($urandom),
                              1'($urandom));
                made++;
            end
            else if (pick < 82)
            begin
                steps = $urandom_range(2, 14);
                queue_request(obms_pkg::KIND_START, 12'($urandom), 12'($urandom),
                              1'($urandom));
                repeat (steps)
                    queue_request(obms_pkg::KIND_STEP, 12'($urandom), 12'($urandom),
                                  1'($urandom));
                made += steps + 1;
            end
            else if (pick < 88)
            begin
                queue_request(obms_pkg::KIND_STEP, 12'($urandom), 12'($urandom),
                              1'($urandom));
                made++;
            end
            else if (pick < 93)
            begin
                queue_request(obms_pkg::KIND_CLEAR, 12'($urandom), 12'($urandom),
                              1'($urandom));
                made++;
            end
            else
            begin
                queue_request(3'($urandom_range(5, 7)), 12'($urandom), 12'($urandom),
                              1'($urandom));
                made++;
            end
        end
    endtask

    initial
    begin
        foreach (word_mem[i])
            word_mem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // step before any start, then header with the entry point from reset
        queue_request(obms_pkg::KIND_STEP, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_START, 12'h000, 12'h000, 1'b0);
        drain();

        write_entry(12'hFFF);
        queue_request(obms_pkg::KIND_FETCH, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_DEFINE, 12'h000, 12'hFFF, 1'b0);
        queue_request(obms_pkg::KIND_DEFINE, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_DEFINE, 12'h000, 12'hABC, 1'b1);
        queue_request(obms_pkg::KIND_DEFINE, 12'hFFF, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_FETCH, 12'hFFF, 12'hFFF, 1'b1);
        queue_request(obms_pkg::KIND_FETCH, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_DEFINE, 12'h001, 12'h555, 1'b1);
        queue_request(obms_pkg::KIND_DEFINE, 12'h002, 12'hAAA, 1'b0);
        queue_request(KIND_RSVD5, 12'hFFF, 12'hFFF, 1'b1);
        queue_request(KIND_RSVD6, 12'h000, 12'h000, 1'b0);
        queue_request(KIND_RSVD7, 12'hFFF, 12'hFFF, 1'b1);
        queue_request(obms_pkg::KIND_START, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_STEP, 12'h000, 12'h000, 1'b0);
        // clear and redefine while a block is still being emitted
        queue_request(obms_pkg::KIND_CLEAR, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_STEP, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_DEFINE, 12'h002, 12'h123, 1'b0);
        queue_request(obms_pkg::KIND_STEP, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_STEP, 12'h000, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_FETCH, 12'h001, 12'h000, 1'b0);
        queue_request(obms_pkg::KIND_START, 12'h000, 12'h000, 1'b0);
        repeat (4)
            queue_request(obms_pkg::KIND_STEP, 12'h000, 12'h000, 1'b0);
        drain();

        write_entry(12'h000);
        queue_random_mix(55);
        drain();

        // back to back requests with no output stalls
        write_entry(12'($urandom));
        steady = 1'b1;
        queue_random_mix(25);
        drain();
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/obms_pkg.sv
hdl/obms_word_store.sv
hdl/obms_mark_store.sv
hdl/obms_seq.sv
hdl/object_memory_block_serializer_top.sv
sim/testbench.sv
